// ===== design/urlpd_pkg.sv =====
// urlpd_pkg: types, character constants and hex helpers for the url percent decoder
// used by every module of the decoder; no dependencies

package urlpd_pkg;

  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam int         MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } urlpd_phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } urlpd_in_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
  } urlpd_out_t;

  typedef struct packed {
    logic [1:0]                   cnt;
    logic                         last;
    logic [MAX_RESULTS-1:0][7:0]  data;
  } urlpd_cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } urlpd_qstat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (c >= 8'h41) begin
      t = (c & ~CHR_SPACE) - 8'h41 + 8'd10;
    end else begin
      t = c - 8'h30;
    end
    return t[3:0];
  endfunction

endpackage

// ===== design/urlpd_front.sv =====
// urlpd_front: accepts encoded bytes, tracks the escape phase and builds one command
// of up to three output bytes per input beat; uses urlpd_pkg

module urlpd_front import urlpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  urlpd_in_t    in_data,
  input  urlpd_qstat_t q_stat,
  output logic         push,
  output urlpd_cmd_t   push_cmd
);

  urlpd_phase_t phase_r, phase_nxt, phase_raw;
  logic [7:0]   digit_r, digit_nxt;
  logic         accept;
  logic [7:0]   c;
  logic         hex;
  logic         fresh_emit;
  logic [7:0]   fresh_val;

  assign c          = in_data.byte_in;
  assign hex        = is_hex(c);
  assign fresh_emit = (c != CHR_PERCENT);
  assign fresh_val  = (c == CHR_PLUS) ? CHR_SPACE : c;
  assign in_stall   = q_stat.full;
  assign accept     = in_valid && !in_stall;

  // next state
  always_comb begin
    phase_raw = PH_IDLE;
    digit_nxt = digit_r;
    case (phase_r)
      PH_PCT: begin
        if (hex) begin
          phase_raw = PH_DIGIT;
          digit_nxt = c;
        end else begin
          phase_raw = fresh_emit ? PH_IDLE : PH_PCT;
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          phase_raw = PH_IDLE;
        end else begin
          phase_raw = fresh_emit ? PH_IDLE : PH_PCT;
        end
      end
      default: begin
        phase_raw = fresh_emit ? PH_IDLE : PH_PCT;
      end
    endcase
    phase_nxt = in_data.last_in ? PH_IDLE : phase_raw;
  end

  // command bytes
  always_comb begin
    logic [1:0]                  n;
    logic [MAX_RESULTS-1:0][7:0] d;
    n = 2'd0;
    d = '0;
    case (phase_r)
      PH_PCT: begin
        if (!hex) begin
          d[n] = CHR_PERCENT;
          n    = n + 2'd1;
          if (fresh_emit) begin
            d[n] = fresh_val;
            n    = n + 2'd1;
          end
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          d[n] = {hex_val(digit_r), hex_val(c)};
          n    = n + 2'd1;
        end else begin
          d[n] = CHR_PERCENT;
          n    = n + 2'd1;
          d[n] = digit_r;
          n    = n + 2'd1;
          if (fresh_emit) begin
            d[n] = fresh_val;
            n    = n + 2'd1;
          end
        end
      end
      default: begin
        if (fresh_emit) begin
          d[n] = fresh_val;
          n    = n + 2'd1;
        end
      end
    endcase
    // flush a pending escape at end of string
    if (in_data.last_in) begin
      case (phase_raw)
        PH_PCT: begin
          d[n] = CHR_PERCENT;
          n    = n + 2'd1;
        end
        PH_DIGIT: begin
          d[n] = CHR_PERCENT;
          n    = n + 2'd1;
          d[n] = c;
          n    = n + 2'd1;
        end
        default: begin
        end
      endcase
    end
    push_cmd.cnt  = n;
    push_cmd.last = in_data.last_in;
    push_cmd.data = d;
    push          = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      digit_r <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
    end
  end

endmodule

// ===== design/urlpd_queue.sv =====
// urlpd_queue: small command queue between front and back of the decoder
// uses urlpd_pkg for the command and status types

module urlpd_queue import urlpd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  urlpd_cmd_t   push_cmd,
  input  logic         pop,
  output urlpd_cmd_t   head_cmd,
  output urlpd_qstat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  urlpd_cmd_t      mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign q_stat.valid = (count_r != '0);
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign head_cmd     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/urlpd_back.sv =====
// urlpd_back: takes commands from the queue and sends their bytes one beat per cycle
// while out_stall is low, through a registered output stage; uses urlpd_pkg

module urlpd_back import urlpd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  urlpd_cmd_t   head_cmd,
  input  urlpd_qstat_t q_stat,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output urlpd_out_t   out_data
);

  urlpd_cmd_t  cur_r;
  logic        cur_valid_r, cur_valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  urlpd_out_t  out_r;
  logic        advance;
  logic        emit;
  logic        final_byte;
  logic        cur_done;

  assign advance    = !out_valid_r || !out_stall;
  assign emit       = cur_valid_r && advance;
  assign final_byte = (idx_r == (cur_r.cnt - 2'd1));
  assign cur_done   = emit && final_byte;
  assign pop        = q_stat.valid && (!cur_valid_r || cur_done);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = 2'd0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (advance ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_cmd;
    end
    if (emit) begin
      out_r.byte_out <= cur_r.data[idx_r];
      out_r.last_out <= cur_r.last && final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/url_percent_decoder_core.sv =====
// url_percent_decoder_core: streaming url percent decoder, top level
// instantiates urlpd_front, urlpd_queue and urlpd_back; uses urlpd_pkg
//
// usage
//   input channel: one encoded byte per beat (in_valid, in_stall, in_data), last_in
//   set on the final byte of a string. output channel: one decoded byte per beat
//   (out_valid, out_stall, out_data), last_out set on the final decoded byte.
//   an input beat gives zero to three output beats: "%hh" gives one byte, '+' gives
//   a space, a broken escape gives its held bytes back, and the end of a string
//   flushes a pending escape.
//   throughput: one input beat per cycle while each beat gives at most one output
//   byte and out_stall is low; an input beat that gives more bytes holds the output
//   side until they are sent; the single output register sets this limit. the queue
//   (QUEUE_DEPTH entries) absorbs bursts, and in_stall rises only when it is full.
//   path: a beat's bytes pass a queue entry, cur_r and out_r before out_valid.
//   reset: synchronous, active low; clears the escape phase, empties the queue and
//   drops out_valid. no clearing pass is needed after reset.
//   output stall: out_data holds while out_valid and out_stall are high; the queue
//   keeps taking input until it fills.

module url_percent_decoder_core import urlpd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  urlpd_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output urlpd_out_t out_data
);

  urlpd_qstat_t q_stat;
  urlpd_cmd_t   push_cmd;
  urlpd_cmd_t   head_cmd;
  logic         push;
  logic         pop;

  urlpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  urlpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  urlpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // no write into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
    else $error("push into full queue");

  // no read from an empty queue
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // a command pushed is never empty and a last beat always carries bytes
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_in) |-> (push && (push_cmd.cnt != 2'd0)))
    else $error("last byte produced no output");

  // output idle right after reset
  assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("out_valid after reset");

endmodule

// ===== dv/urlpd_checker.sv =====
// urlpd_checker: watches both channels of the url percent decoder, predicts decoded beats
// and compares them in order; depends on urlpd_pkg for the beat types and characters

module urlpd_checker import urlpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  urlpd_in_t  in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  urlpd_out_t out_data,
  output int         fail_count,
  output int         pending,
  output int         beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  urlpd_phase_t     esc_phase;
  logic [7:0]       held_digit;
  urlpd_out_t       decoded_q[$];
  logic [2:0][7:0]  dec_bytes;
  int               dec_cnt;
  urlpd_out_t       want;

  function automatic logic hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | 8'h20;
    if (lc >= "a") begin
      return 4'(lc - 8'h57);
    end
    return c[3:0];
  endfunction

  // advances the escape state by one input beat, gives the decoded bytes in res and returns their count
  function automatic int decode_beat(input urlpd_in_t b, output logic [2:0][7:0] res);
    int         n;
    logic [7:0] c;
    logic       redo;
    n    = 0;
    c    = b.byte_in;
    redo = 1'b0;
    res  = '0;
    case (esc_phase)
      PH_PCT: begin
        if (hex_char(c)) begin
          held_digit = c;
          esc_phase  = PH_DIGIT;
        end else begin
          res[n] = CHR_PERCENT;
          n++;
          esc_phase = PH_IDLE;
          redo = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hex_char(c)) begin
          res[n] = {nibble(held_digit), nibble(c)};
          n++;
          esc_phase = PH_IDLE;
        end else begin
          res[n] = CHR_PERCENT;
          n++;
          res[n] = held_digit;
          n++;
          esc_phase = PH_IDLE;
          redo = 1'b1;
        end
      end
      default: begin
        esc_phase = PH_IDLE;
        redo = 1'b1;
      end
    endcase
    if (redo) begin
      if (c == CHR_PERCENT) begin
        esc_phase = PH_PCT;
      end else if (c == CHR_PLUS) begin
        res[n] = CHR_SPACE;
        n++;
      end else begin
        res[n] = c;
        n++;
      end
    end
    if (b.last_in) begin
      // flush a pending escape at end of string
      if (esc_phase == PH_PCT) begin
        res[n] = CHR_PERCENT;
        n++;
      end else if (esc_phase == PH_DIGIT) begin
        res[n] = CHR_PERCENT;
        n++;
        res[n] = held_digit;
        n++;
      end
      esc_phase = PH_IDLE;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    if (fail_count < 40) begin
      $display("mismatch: %s got %h want %h (out beat %0d)", what, got, exp_val,
               beats_checked);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      esc_phase  = PH_IDLE;
      held_digit = '0;
      decoded_q.delete();
      pending    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected beat, byte", out_data.byte_out, 8'h00);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.byte_out !== want.byte_out) begin
            report_mismatch("byte_out", out_data.byte_out, want.byte_out);
          end
          if (out_data.last_out !== want.last_out) begin
            report_mismatch("last_out", 8'(out_data.last_out), 8'(want.last_out));
          end
        end
        beats_checked++;
      end
      if (in_valid && !in_stall) begin
        dec_cnt = decode_beat(in_data, dec_bytes);
        for (int i = 0; i < dec_cnt; i++) begin
          want.byte_out = dec_bytes[i];
          want.last_out = in_data.last_in && (i == dec_cnt - 1);
          decoded_q.push_back(want);
        end
      end
      pending = decoded_q.size();
    end
  end

endmodule

// ===== dv/tb_url_percent_decoder_core.sv =====
// tb_url_percent_decoder_core: drives encoded strings into the decoder with random gaps
// and output stalls; relies on urlpd_checker for prediction and on urlpd_pkg for types

module tb_url_percent_decoder_core;
  import urlpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 60000;
  localparam int RAND_ITEMS  = 250;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  urlpd_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  urlpd_out_t out_data;

  int fail_count;
  int pending;
  int beats_checked;
  int cycle_cnt = 0;
  int n_strings = 0;
  int n_directed;
  bit calm = 1'b0;

  urlpd_in_t stim_q[$];

  url_percent_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  urlpd_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic push_item(input logic [7:0] b, input logic l);
    urlpd_in_t t;
    t.byte_in = b;
    t.last_in = l;
    stim_q.push_back(t);
    if (l) n_strings++;
  endtask

  task automatic push_text(input string s, input bit last_flag);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], last_flag && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic gen_string();
    logic [7:0] buf_q[$];
    int         target;
    logic [7:0] c;
    target = $urandom_range(1, 10);
    while (buf_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          buf_q.push_back(CHR_PERCENT);
          buf_q.push_back(pick_hex());
          buf_q.push_back(pick_hex());
        end
        4: buf_q.push_back(CHR_PLUS);
        5, 6: buf_q.push_back(8'($urandom_range(1, 255)));
        7: begin
          // escape broken by a non-hex byte
          buf_q.push_back(CHR_PERCENT);
          if ($urandom_range(0, 1)) buf_q.push_back(pick_hex());
          do begin
            c = 8'($urandom_range(1, 255));
          end while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
                     (c >= "a" && c <= "f"));
          buf_q.push_back(c);
        end
        8: buf_q.push_back(CHR_PERCENT);
        default: begin
          buf_q.push_back(CHR_PERCENT);
          buf_q.push_back(pick_hex());
        end
      endcase
    end
    foreach (buf_q[i]) push_item(buf_q[i], i == buf_q.size() - 1);
  endtask

  initial begin : timeout
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, pending);
    $display("[url_percent_decoder_core] ERROR");
    $finish;
  end

  // output side: random stall, possibly none, before every beat; no stall while calm is set
  initial begin : sink
    int hold;
    bit hit;
    wait (rst_n === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        hit = out_valid;
        @(posedge clk);
      end while (!hit);
    end
  end

  initial begin : source
    int gap;
    bit hit;
    push_text("%6a+", 1'b1);
    push_text("%4g", 1'b0);
    push_text("%%41", 1'b1);
    push_text("%4+", 1'b1);
    push_text("%", 1'b1);
    push_text("%B", 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h01, 1'b0);
    push_text("%fF", 1'b1);
    push_text("%z", 1'b1);
    n_directed = stim_q.size();
    while (stim_q.size() < n_directed + RAND_ITEMS) gen_string();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (stim_q[i]) begin
      if (i == 0 || stim_q[i-1].last_in) calm = ($urandom_range(0, 4) == 0);
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= stim_q[i];
      do begin
        @(negedge clk);
        hit = !in_stall;
        @(posedge clk);
      end while (!hit);
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (24) @(posedge clk);

    $display("ran %0d input beats (%0d directed) in %0d strings", stim_q.size(),
             n_directed, n_strings);
    $display("checked %0d decoded beats with random gaps and stalls", beats_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[url_percent_decoder_core] OK");
    end else begin
      $display("[url_percent_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
